// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// clocked checks on clk, held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define SWLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SWLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/swlc_pkg.sv =====
// ----------------------------------------------------------------------------
// swlc_pkg
// shared types and constants of the stop-and-wait link controller
// ----------------------------------------------------------------------------
package swlc_pkg;

  // sender table size and header length
  localparam int HOST_ENTRIES = 5;
  localparam int HEADER_BYTES = 5;
  localparam int HOST_IDX_W   = (HOST_ENTRIES > 1) ? $clog2(HOST_ENTRIES) : 1;
  localparam logic [HOST_IDX_W-1:0] HOST_LAST = HOST_IDX_W'(HOST_ENTRIES - 1);

  // port widths
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 32;
  localparam int ACTION_W    = 3;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;

  // item kinds
  localparam logic [ACTION_W-1:0] ACT_TICK    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_RECV    = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_SEND    = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_CONSUME = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_POLL    = 3'd4;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_OWN_ADDR  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SNIFF     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_RETRY     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_LIFETIME  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_BCAST     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_MCAST     = 3'd5;

  // register reset values
  localparam logic [7:0]  RST_OWN_ADDR = 8'h23;
  localparam logic [7:0]  RST_RETRY    = 8'd20;
  localparam logic [15:0] RST_LIFETIME = 16'd1000;
  localparam logic [7:0]  RST_BCAST    = 8'd255;
  localparam logic [7:0]  RST_MCAST    = 8'd128;

  // one latched input item
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [7:0]          dest;
    logic [7:0]          src;
    logic [7:0]          seq;
    logic                ack;
    logic [7:0]          plen;
    logic [7:0]          flen;
  } item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_step;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic match;
    logic last;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/swlc_ctrl.sv =====
// ----------------------------------------------------------------------------
// swlc_ctrl
// sequencer: accept a beat, scan the sender table for received headers,
// then commit the result once the output register is free
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swlc_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [swlc_pkg::ACTION_W-1:0]   in_action,
  output swlc_pkg::cmd_t                  cmd,
  input  swlc_pkg::sts_t                  sts
);
  import swlc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd.load      = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.commit    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load = in_tvalid;
        if (in_tvalid) begin
          state_nxt = (in_action == ACT_RECV) ? ST_SCAN : ST_EXEC;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.match || sts.last) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.commit = sts.out_free;
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `SWLC_ASSERT_NEXT(a_one_item, cmd.load, !in_tready, "second beat taken while busy")
  `SWLC_ASSERT_NEXT(a_scan_ends, (state_r == ST_SCAN) && sts.last, state_r == ST_EXEC,
                    "table scan ran past the last entry")

endmodule

// ===== sv/swlc_dpath.sv =====
// ----------------------------------------------------------------------------
// swlc_dpath
// link state, sender table, configuration registers and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module swlc_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [swlc_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic [swlc_pkg::ACTION_W-1:0]     in_action,
  input  logic                              cfg_we,
  input  logic [swlc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [swlc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  swlc_pkg::cmd_t                    cmd,
  output swlc_pkg::sts_t                    sts,
  input  logic                              out_tready,
  output logic                              out_tvalid,
  output logic [swlc_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import swlc_pkg::*;

  // configuration
  logic [7:0]  own_addr_r;
  logic        sniff_r;
  logic [7:0]  retry_ticks_r;
  logic [15:0] lifetime_r;
  logic [7:0]  bcast_r;
  logic [7:0]  mcast_r;

  // link state
  logic [7:0] expect_r, expect_nxt;
  logic       acked_r, acked_nxt;
  logic [7:0] retry_r, retry_nxt;
  logic [7:0] last_dest_r, last_dest_nxt;
  logic       fired_r, fired_nxt;
  logic       inbound_r, inbound_nxt;

  // sender table
  logic [7:0]            tbl_src_r  [HOST_ENTRIES];
  logic [7:0]            tbl_seq_r  [HOST_ENTRIES];
  logic [15:0]           tbl_life_r [HOST_ENTRIES];
  logic [HOST_IDX_W-1:0] ins_ptr_r;

  // item and scan result
  item_t                 item_r;
  logic [HOST_IDX_W-1:0] scan_idx_r;
  logic                  hit_r;
  logic [HOST_IDX_W-1:0] hit_idx_r;
  logic [7:0]            hit_seq_r;
  logic                  hit_life0_r;

  // result register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  // commit decisions
  logic       life_dec, wr_life, wr_seq, tbl_ins, do_send, done;
  logic       tx_v, tx_a, del;
  logic [7:0] tx_d, tx_s, tx_q;
  logic [7:0] send_dest;
  logic       short_frame, take, fresh, uni_dest, bc_dest, send_uni;

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign sts.out_free = !out_valid_r || out_tready;
  assign sts.match    = (tbl_src_r[scan_idx_r] == item_r.src);
  assign sts.last     = (scan_idx_r == HOST_LAST);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r    <= RST_OWN_ADDR;
      sniff_r       <= 1'b0;
      retry_ticks_r <= RST_RETRY;
      lifetime_r    <= RST_LIFETIME;
      bcast_r       <= RST_BCAST;
      mcast_r       <= RST_MCAST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_OWN_ADDR: own_addr_r    <= cfg_wdata[7:0];
        CFG_SNIFF:    sniff_r       <= cfg_wdata[0];
        CFG_RETRY:    retry_ticks_r <= cfg_wdata[7:0];
        CFG_LIFETIME: lifetime_r    <= cfg_wdata;
        CFG_BCAST:    bcast_r       <= cfg_wdata[7:0];
        CFG_MCAST:    mcast_r       <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // item latch and table scan
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r.action <= in_action;
      item_r.dest   <= in_tdata[7:0];
      item_r.src    <= in_tdata[15:8];
      item_r.seq    <= in_tdata[23:16];
      item_r.ack    <= in_tdata[24];
      item_r.plen   <= in_tdata[32:25];
      item_r.flen   <= in_tdata[40:33];
      scan_idx_r    <= '0;
      hit_r         <= 1'b0;
    end else if (cmd.scan_step) begin
      if (sts.match) begin
        hit_r       <= 1'b1;
        hit_idx_r   <= scan_idx_r;
        hit_seq_r   <= tbl_seq_r[scan_idx_r];
        hit_life0_r <= (tbl_life_r[scan_idx_r] == 16'd0);
      end else if (!sts.last) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
    end
  end

  // destination classes
  assign bc_dest   = (item_r.dest == bcast_r);
  assign uni_dest  = !bc_dest && ((item_r.dest & mcast_r) == 8'd0);
  assign send_dest = (item_r.action == ACT_SEND) ? item_r.dest : last_dest_r;
  assign send_uni  = (send_dest != bcast_r) && ((send_dest & mcast_r) == 8'd0);
  assign short_frame = ({1'b0, item_r.plen} + 9'(HEADER_BYTES)) > {1'b0, item_r.flen};
  assign take  = bc_dest || (item_r.dest == own_addr_r) || sniff_r;
  assign fresh = (hit_seq_r != item_r.seq);

  // per-item update of link state and result
  always_comb begin
    expect_nxt    = expect_r;
    acked_nxt     = acked_r;
    retry_nxt     = retry_r;
    last_dest_nxt = last_dest_r;
    fired_nxt     = fired_r;
    inbound_nxt   = inbound_r;
    life_dec = 1'b0;
    wr_life  = 1'b0;
    wr_seq   = 1'b0;
    tbl_ins  = 1'b0;
    do_send  = 1'b0;
    done     = 1'b0;
    del      = 1'b0;
    tx_v = 1'b0;
    tx_d = 8'd0;
    tx_s = 8'd0;
    tx_q = 8'd0;
    tx_a = 1'b0;
    case (item_r.action)
      ACT_TICK: begin
        life_dec = 1'b1;
        if (!acked_r && (retry_r != 8'd0)) begin
          retry_nxt = retry_r - 8'd1;
          do_send   = (retry_r == 8'd1);
        end
      end
      ACT_RECV: begin
        if (!short_frame && take) begin
          if (item_r.ack && (item_r.seq == expect_r)) begin
            expect_nxt = expect_r + 8'd1;
            acked_nxt  = 1'b1;
          end
          if ((item_r.plen != 8'd0) && !inbound_r) begin
            priority if (sniff_r) begin
              del = 1'b1;
            end else if (!acked_nxt) begin
              // repeat while our own send is pending: re-acknowledge only
              if (uni_dest && hit_r && !fresh && !hit_life0_r) begin
                tx_v = 1'b1;
                tx_a = 1'b1;
              end
            end else if (uni_dest) begin
              tx_v = 1'b1;
              tx_a = 1'b1;
              if (hit_r) begin
                del     = fresh || hit_life0_r;
                wr_life = fresh || hit_life0_r;
                wr_seq  = fresh;
              end else begin
                tbl_ins = 1'b1;
                del     = 1'b1;
              end
            end else if (bc_dest) begin
              del = 1'b1;
            end else begin
            end
          end
        end
        if (tx_a) begin
          tx_d = item_r.src;
          tx_s = item_r.dest;
          tx_q = item_r.seq;
        end
        if (del) begin
          inbound_nxt = 1'b1;
        end
      end
      ACT_SEND: begin
        last_dest_nxt = item_r.dest;
        do_send       = 1'b1;
      end
      ACT_CONSUME: inbound_nxt = 1'b0;
      ACT_POLL: begin
        if (fired_r && acked_r) begin
          fired_nxt = 1'b0;
          done      = 1'b1;
        end
      end
      default: ;
    endcase
    // (re)transmit the outstanding frame
    if (do_send) begin
      retry_nxt = retry_ticks_r;
      acked_nxt = !send_uni;
      fired_nxt = 1'b1;
      tx_v = 1'b1;
      tx_d = send_dest;
      tx_s = own_addr_r;
      tx_q = expect_r;
      tx_a = 1'b0;
    end
  end

  // link state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_r    <= 8'd0;
      acked_r     <= 1'b1;
      retry_r     <= 8'd0;
      last_dest_r <= 8'd0;
      fired_r     <= 1'b0;
      inbound_r   <= 1'b0;
    end else if (cmd.commit) begin
      expect_r    <= expect_nxt;
      acked_r     <= acked_nxt;
      retry_r     <= retry_nxt;
      last_dest_r <= last_dest_nxt;
      fired_r     <= fired_nxt;
      inbound_r   <= inbound_nxt;
    end
  end

  // sender table updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HOST_ENTRIES; i++) begin
        tbl_src_r[i]  <= 8'd0;
        tbl_seq_r[i]  <= 8'd0;
        tbl_life_r[i] <= 16'd0;
      end
      ins_ptr_r <= '0;
    end else if (cmd.commit) begin
      if (life_dec) begin
        for (int i = 0; i < HOST_ENTRIES; i++) begin
          if (tbl_life_r[i] != 16'd0) begin
            tbl_life_r[i] <= tbl_life_r[i] - 16'd1;
          end
        end
      end
      if (wr_life) begin
        tbl_life_r[hit_idx_r] <= lifetime_r;
      end
      if (wr_seq) begin
        tbl_seq_r[hit_idx_r] <= item_r.seq;
      end
      if (tbl_ins) begin
        tbl_src_r[ins_ptr_r]  <= item_r.src;
        tbl_seq_r[ins_ptr_r]  <= item_r.seq;
        tbl_life_r[ins_ptr_r] <= lifetime_r;
        ins_ptr_r <= (ins_ptr_r == HOST_LAST) ? '0 : ins_ptr_r + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= {2'b00, done, acked_nxt, inbound_nxt, del, tx_a, tx_q, tx_s, tx_d, tx_v};
    end
  end

  `SWLC_ASSERT(a_pending_fired, !acked_r |-> fired_r, "pending send without fired flag")
  `SWLC_ASSERT(a_ptr_range, ins_ptr_r <= HOST_LAST, "insert pointer out of table")
  `SWLC_ASSERT_NEXT(a_commit_out, cmd.commit, out_valid_r, "committed result not presented")

endmodule

// ===== sv/stop_and_wait_link_control.sv =====
// flow: a tick, send, consume, poll or unused-kind beat goes from acceptance to the commit state;
//   a received header first scans the sender table, one entry per cycle, to a match or the last entry
// a new beat is taken only once the last one is committed to the out register, and a stalled
//   out beat holds the next commit
// reset: synchronous active-low rst_n clears link state, sender table and config to defaults
// ----------------------------------------------------------------------------
// stop_and_wait_link_control
// stop-and-wait link control with acknowledge, retransmit and duplicate filter
// ----------------------------------------------------------------------------
module stop_and_wait_link_control (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // dest_addr, src_addr, seq_num, ack_bit, payload_len, frame_len, zero pad
  input  logic [swlc_pkg::IN_TDATA_W-1:0]   in_tdata,
  // action
  input  logic [swlc_pkg::ACTION_W-1:0]     in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tx_valid, tx_dest, tx_src, tx_seq, tx_is_ack, delivered, inbound_busy,
  // link_acked, send_done, zero pad
  output logic [swlc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              cfg_we,
  input  logic [swlc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [swlc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import swlc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  swlc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_action (in_tuser),
    .cmd       (cmd),
    .sts       (sts)
  );

  // state, table and result
  swlc_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_action  (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== tb/stop_and_wait_link_control_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stop_and_wait_link_control_tb
// drives ticks, received headers, send requests, consume notices and done
// polls into the link controller under bursty input and a stalling output,
// predicts each status beat in a small tracker class and compares it field by
// field, across several register settings including the extremes
// ----------------------------------------------------------------------------
import swlc_pkg::*;

// one status beat as it leaves the block
typedef struct packed {
  logic       tx_valid;
  logic [7:0] tx_dest;
  logic [7:0] tx_src;
  logic [7:0] tx_seq;
  logic       tx_is_ack;
  logic       delivered;
  logic       inbound_busy;
  logic       link_acked;
  logic       send_done;
} report_t;

// link state tracker: predicts one status beat per input beat
class link_tracker;
  logic [7:0]  own_addr;
  logic        sniff;
  logic [7:0]  retry_ticks;
  logic [15:0] lifetime;
  logic [7:0]  bcast_addr;
  logic [7:0]  mcast_mask;

  logic [7:0]  expect_seq;
  logic        acked;
  logic [7:0]  retry_cnt;
  logic [7:0]  last_dest;
  logic        fired;
  logic        inbound;
  logic [7:0]  host_src [HOST_ENTRIES];
  logic [7:0]  host_seq [HOST_ENTRIES];
  logic [15:0] host_life [HOST_ENTRIES];
  int          ins_ptr;

  report_t     cur;
  report_t     pending_reports[$];
  int          errors;
  int          beats_in;
  int          beats_out;
  int          frames;
  int          acks_sent;
  int          deliveries;
  int          done_reports;

  function new();
    own_addr    = RST_OWN_ADDR;
    sniff       = 1'b0;
    retry_ticks = RST_RETRY;
    lifetime    = RST_LIFETIME;
    bcast_addr  = RST_BCAST;
    mcast_mask  = RST_MCAST;
    expect_seq  = '0;
    acked       = 1'b1;
    retry_cnt   = '0;
    last_dest   = '0;
    fired       = 1'b0;
    inbound     = 1'b0;
    for (int i = 0; i < HOST_ENTRIES; i++) begin
      host_src[i]  = '0;
      host_seq[i]  = '0;
      host_life[i] = '0;
    end
    ins_ptr = 0;
  endfunction

  function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_OWN_ADDR: own_addr    = val[7:0];
      CFG_SNIFF:    sniff       = val[0];
      CFG_RETRY:    retry_ticks = val[7:0];
      CFG_LIFETIME: lifetime    = val[15:0];
      CFG_BCAST:    bcast_addr  = val[7:0];
      CFG_MCAST:    mcast_mask  = val[7:0];
      default: ;
    endcase
  endfunction

  function bit is_bcast(logic [7:0] d);
    return d == bcast_addr;
  endfunction

  function bit is_ucast(logic [7:0] d);
    return !is_bcast(d) && ((d & mcast_mask) == 8'd0);
  endfunction

  function void emit(logic [7:0] d, logic [7:0] s, logic [7:0] q, logic a);
    cur.tx_valid  = 1'b1;
    cur.tx_dest   = d;
    cur.tx_src    = s;
    cur.tx_seq    = q;
    cur.tx_is_ack = a;
  endfunction

  function void start_send();
    retry_cnt = retry_ticks;
    acked     = !is_ucast(last_dest);
    emit(last_dest, own_addr, expect_seq, 1'b0);
    fired = 1'b1;
  endfunction

  // true when the packet is not a repeat; update writes the sender table
  function bit fresh_packet(logic [7:0] src, logic [7:0] seq, bit update);
    bit changed;
    bit pass;
    for (int i = 0; i < HOST_ENTRIES; i++) begin
      if (host_src[i] == src) begin
        changed = host_seq[i] != seq;
        pass    = changed || (host_life[i] == 16'd0);
        if (pass && update) host_life[i] = lifetime;
        if (changed && update) host_seq[i] = seq;
        return pass;
      end
    end
    if (!update) return 1'b1;
    // round-robin replacement
    host_src[ins_ptr]  = src;
    host_seq[ins_ptr]  = seq;
    host_life[ins_ptr] = lifetime;
    ins_ptr = (ins_ptr + 1) % HOST_ENTRIES;
    return 1'b1;
  endfunction

  function void deliver();
    inbound = 1'b1;
    cur.delivered = 1'b1;
  endfunction

  function void take_header(item_t it);
    // short frame and foreign destination are dropped
    if (int'(it.plen) + HEADER_BYTES > int'(it.flen)) return;
    if (!(is_bcast(it.dest) || it.dest == own_addr || sniff)) return;
    if (it.ack && it.seq == expect_seq) begin
      expect_seq = expect_seq + 8'd1;
      acked = 1'b1;
    end
    if (it.plen == 8'd0 || inbound) return;
    if (sniff) begin
      deliver();
    end else if (!acked) begin
      if (is_ucast(it.dest) && !fresh_packet(it.src, it.seq, 1'b0))
        emit(it.src, it.dest, it.seq, 1'b1);
    end else if (is_ucast(it.dest)) begin
      emit(it.src, it.dest, it.seq, 1'b1);
      if (fresh_packet(it.src, it.seq, 1'b1)) deliver();
    end else if (is_bcast(it.dest)) begin
      deliver();
    end
  endfunction

  // note an accepted input beat and queue its status beat
  function void take_item(item_t it);
    cur = '0;
    case (it.action)
      ACT_TICK: begin
        for (int i = 0; i < HOST_ENTRIES; i++)
          if (host_life[i] != 16'd0) host_life[i] = host_life[i] - 16'd1;
        if (!acked && retry_cnt != 8'd0) begin
          retry_cnt = retry_cnt - 8'd1;
          if (retry_cnt == 8'd0) start_send();
        end
      end
      ACT_RECV: take_header(it);
      ACT_SEND: begin
        last_dest = it.dest;
        start_send();
      end
      ACT_CONSUME: inbound = 1'b0;
      ACT_POLL: begin
        if (fired && acked) begin
          fired = 1'b0;
          cur.send_done = 1'b1;
        end
      end
      default: ;
    endcase
    cur.inbound_busy = inbound;
    cur.link_acked   = acked;
    pending_reports.push_back(cur);
    beats_in++;
  endfunction

  function void field_ok(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  // compare an accepted status beat with the oldest prediction
  function void check_report(report_t got);
    report_t want;
    if (pending_reports.size() == 0) begin
      $error("status beat with no prediction waiting");
      errors++;
      return;
    end
    want = pending_reports.pop_front();
    field_ok("tx_valid", want.tx_valid, got.tx_valid);
    field_ok("tx_dest", want.tx_dest, got.tx_dest);
    field_ok("tx_src", want.tx_src, got.tx_src);
    field_ok("tx_seq", want.tx_seq, got.tx_seq);
    field_ok("tx_is_ack", want.tx_is_ack, got.tx_is_ack);
    field_ok("delivered", want.delivered, got.delivered);
    field_ok("inbound_busy", want.inbound_busy, got.inbound_busy);
    field_ok("link_acked", want.link_acked, got.link_acked);
    field_ok("send_done", want.send_done, got.send_done);
    beats_out++;
    if (got.tx_valid && !got.tx_is_ack) frames++;
    if (got.tx_valid && got.tx_is_ack) acks_sent++;
    if (got.delivered) deliveries++;
    if (got.send_done) done_reports++;
  endfunction
endclass

module stop_and_wait_link_control_tb;

  // action codes the block leaves unused
  localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // dest_addr, src_addr, seq_num, ack_bit, payload_len, frame_len, zero pad
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  // action
  logic [ACTION_W-1:0]    in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // tx_valid, tx_dest, tx_src, tx_seq, tx_is_ack, delivered, inbound_busy,
  // link_acked, send_done, zero pad
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  link_tracker tracker;
  report_t     rx_beat;
  int          rx_cycle = 0;
  logic [7:0]  last_seq_from [256];

  stop_and_wait_link_control uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: check accepted beats, stall in shifting patterns
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      rx_beat.tx_valid     = out_tdata[0];
      rx_beat.tx_dest      = out_tdata[8:1];
      rx_beat.tx_src       = out_tdata[16:9];
      rx_beat.tx_seq       = out_tdata[24:17];
      rx_beat.tx_is_ack    = out_tdata[25];
      rx_beat.delivered    = out_tdata[26];
      rx_beat.inbound_busy = out_tdata[27];
      rx_beat.link_acked   = out_tdata[28];
      rx_beat.send_done    = out_tdata[29];
      tracker.check_report(rx_beat);
    end
    rx_cycle = rx_cycle + 1;
    case ((rx_cycle / 250) % 4)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 2) != 0);
      2:       out_tready <= ((rx_cycle % 7) < 3);
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // run limit
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic item_t mk(logic [ACTION_W-1:0] action, logic [7:0] dest,
                               logic [7:0] src, logic [7:0] seq, logic ack,
                               logic [7:0] plen, logic [7:0] flen);
    item_t it;
    it.action = action;
    it.dest   = dest;
    it.src    = src;
    it.seq    = seq;
    it.ack    = ack;
    it.plen   = plen;
    it.flen   = flen;
    return it;
  endfunction

  // destination mix: own, broadcast, multicast or anything
  function automatic logic [7:0] pick_dest();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return tracker.own_addr;
    if (r < 60) return tracker.bcast_addr;
    if (r < 72) return 8'($urandom()) | tracker.mcast_mask;
    return 8'($urandom());
  endfunction

  // mostly well-formed traffic shaped by the current link state
  function automatic item_t random_item();
    item_t it;
    int    r;
    r  = $urandom_range(0, 99);
    it = mk(ACT_TICK, 8'($urandom()), 8'($urandom()), 8'($urandom()),
            1'($urandom()), 8'($urandom()), 8'($urandom()));
    if (r < 5) begin
      // noise: any kind, any content
      it.action = 3'($urandom());
    end else if (r < 8) begin
      it.action = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
    end else if (r < 36) begin
      it.action = ACT_TICK;
    end else if (r < 68) begin
      it.action = ACT_RECV;
      it.dest   = pick_dest();
      it.src    = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 6)) : 8'($urandom());
      if ($urandom_range(0, 99) < 40) it.seq = last_seq_from[it.src];
      it.ack = ($urandom_range(0, 99) < 40);
      if (it.ack && $urandom_range(0, 3) != 0) it.seq = tracker.expect_seq;
      last_seq_from[it.src] = it.seq;
      if ($urandom_range(0, 99) < 85) begin
        it.flen = 8'($urandom_range(HEADER_BYTES, 255));
        if ($urandom_range(0, 9) == 0 || it.flen == 8'(HEADER_BYTES))
          it.plen = 8'd0;
        else
          it.plen = 8'($urandom_range(1, int'(it.flen) - HEADER_BYTES));
      end
    end else if (r < 78) begin
      it.action = ACT_SEND;
      it.dest   = ($urandom_range(0, 2) != 0) ? (8'($urandom()) & ~tracker.mcast_mask)
                                               : pick_dest();
    end else if (r < 90) begin
      it.action = ACT_CONSUME;
    end else begin
      it.action = ACT_POLL;
    end
    return it;
  endfunction

  // present one beat and hold it until accepted
  task automatic send_item(item_t it);
    in_tvalid <= 1'b1;
    in_tuser  <= it.action;
    in_tdata  <= {7'd0, it.flen, it.plen, it.ack, it.seq, it.src, it.dest};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.take_item(it);
  endtask

  task automatic idle(int cycles);
    if (cycles > 0) begin
      in_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // hold input until every predicted beat has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending_reports.size() != 0);
  endtask

  task automatic write_cfg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    tracker.write_reg(idx, val);
  endtask

  task automatic configure(logic [7:0] own, logic sniff, logic [7:0] retry,
                           logic [15:0] life, logic [7:0] bcast, logic [7:0] mcast);
    write_cfg(CFG_OWN_ADDR, 16'(own));
    write_cfg(CFG_SNIFF, 16'(sniff));
    write_cfg(CFG_RETRY, 16'(retry));
    write_cfg(CFG_LIFETIME, life);
    write_cfg(CFG_BCAST, 16'(bcast));
    write_cfg(CFG_MCAST, 16'(mcast));
    cfg_we <= 1'b0;
  endtask

  // random bursts with random gaps, one full pause halfway
  task automatic run_random(int count);
    int left;
    int burst;
    bit paused;
    left   = count;
    paused = 1'b0;
    while (left > 0) begin
      burst = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 20);
      for (int i = 0; i < burst && left > 0; i++) begin
        send_item(random_item());
        left--;
      end
      if (!paused && left < count / 2) begin
        paused = 1'b1;
        drain();
      end
      idle(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14));
    end
    drain();
  endtask

  // long run of matching acknowledges so the sequence number wraps
  task automatic ack_run(int count);
    for (int i = 0; i < count; i++)
      send_item(mk(ACT_RECV, tracker.own_addr, 8'($urandom()), tracker.expect_seq, 1'b1,
                   8'd0, 8'($urandom_range(HEADER_BYTES, 255))));
    drain();
  endtask

  initial begin
    tracker = new();
    for (int i = 0; i < 256; i++) last_seq_from[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset values, table hit on reset entries, duplicates, short frames
    configure(RST_OWN_ADDR, 1'b0, RST_RETRY, RST_LIFETIME, RST_BCAST, RST_MCAST);
    send_item(mk(ACT_POLL, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0));
    send_item(mk(ACT_RECV, RST_OWN_ADDR, 8'd0, 8'd0, 1'b0, 8'd1, 8'd6));
    send_item(mk(ACT_RECV, RST_OWN_ADDR, 8'd0, 8'd0, 1'b0, 8'd1, 8'd6));
    send_item(mk(ACT_CONSUME, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0));
    send_item(mk(ACT_RECV, RST_OWN_ADDR, 8'd0, 8'd0, 1'b0, 8'd1, 8'd6));
    send_item(mk(ACT_RECV, RST_OWN_ADDR, 8'd4, 8'd9, 1'b0, 8'd10, 8'd14));
    send_item(mk(ACT_RECV, RST_OWN_ADDR, 8'd4, 8'd9, 1'b0, 8'd255, 8'd255));
    send_item(mk(ACT_RECV, RST_OWN_ADDR, 8'd4, 8'd9, 1'b0, 8'd0, 8'd255));
    // send, then replace it while unacknowledged
    send_item(mk(ACT_SEND, 8'h10, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0));
    send_item(mk(ACT_SEND, 8'h11, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0));
    send_item(mk(ACT_RECV, RST_OWN_ADDR, 8'h11, 8'd5, 1'b1, 8'd2, 8'd7));
    send_item(mk(ACT_RECV, RST_OWN_ADDR, 8'd0, 8'd0, 1'b0, 8'd1, 8'd6));
    send_item(mk(ACT_POLL, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0));
    send_item(mk(ACT_RECV, RST_OWN_ADDR, 8'h11, 8'd0, 1'b1, 8'd0, 8'd5));
    send_item(mk(ACT_POLL, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0));
    send_item(mk(ACT_POLL, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0));
    // broadcast and multicast sends and receives
    send_item(mk(ACT_SEND, RST_BCAST, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0));
    send_item(mk(ACT_SEND, 8'h80, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0));
    send_item(mk(ACT_RECV, 8'h80, 8'd3, 8'd1, 1'b0, 8'd1, 8'd6));
    send_item(mk(ACT_RECV, RST_BCAST, 8'd3, 8'd1, 1'b0, 8'd1, 8'd6));
    send_item(mk(ACT_CONSUME, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0));
    send_item(mk(ACT_TICK, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0));
    send_item(mk(ACT_SPARE_LAST, 8'hff, 8'hff, 8'hff, 1'b1, 8'hff, 8'hff));
    send_item(mk(ACT_SPARE_FIRST, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0));
    drain();
    run_random(200);

    // low extremes: zero lifetime, broadcast 0, no multicast bits, fastest retry
    configure(8'd0, 1'b0, 8'd1, 16'd0, 8'd0, 8'd0);
    run_random(200);

    // high extremes with sniffing
    configure(8'd255, 1'b1, 8'd255, 16'hffff, 8'd255, 8'd255);
    run_random(150);

    // zero retry count, short lifetime, sequence wrap
    configure(8'($urandom()), 1'b0, 8'd0, 16'd3, RST_BCAST, RST_MCAST);
    run_random(200);
    ack_run(260);

    // random settings
    for (int p = 0; p < 4; p++) begin
      configure(8'($urandom()), ($urandom_range(0, 3) == 0), 8'($urandom_range(1, 12)),
                ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(1, 40)),
                ($urandom_range(0, 1) != 0) ? RST_BCAST : 8'($urandom()),
                ($urandom_range(0, 1) != 0) ? 8'h80 << $urandom_range(0, 1)
                                             : 8'($urandom()));
      run_random(190);
    end

    repeat (20) @(posedge clk);
    $display("covered %0d input beats and %0d status beats over 8 register settings",
             tracker.beats_in, tracker.beats_out);
    $display("saw %0d frames, %0d acknowledges, %0d deliveries, %0d done reports",
             tracker.frames, tracker.acks_sent, tracker.deliveries, tracker.done_reports);
    if (tracker.errors == 0 && tracker.pending_reports.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== stop_and_wait_link_control.f =====
+incdir+sv
sv/swlc_pkg.sv
sv/swlc_ctrl.sv
sv/swlc_dpath.sv
sv/stop_and_wait_link_control.sv
tb/stop_and_wait_link_control_tb.sv
